@@ sv/gdad_pkg.sv @@
package gdad_pkg;

    localparam int YEAR_BITS_DEF = 16;
    localparam int ADD_BITS_DEF  = 12;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_LEAP  = 5'd29;
    localparam logic [4:0] LEN_FEB   = 5'd28;

    localparam logic [8:0] QUAD_CENT = 9'd400;
    localparam logic [8:0] CENT_1    = 9'd100;

    // 100 = 4 * 25 and 400 = 16 * 25, so year mod 25 plus the low year bits decide leap years
    localparam logic [4:0] CENT_FACTOR = 5'd25;
    // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT for every 32-bit y
    localparam logic [30:0] RECIP_25    = 31'h51EB851F;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic run_step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic need_sub;
        logic wrap_ovf;
    } sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_LEAP : LEN_FEB;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

@@ sv/gdad_dp.sv @@
module gdad_dp #(
    parameter int YEAR_BITS = gdad_pkg::YEAR_BITS_DEF,
    parameter int ADD_BITS  = gdad_pkg::ADD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gdad_pkg::cmd_t        cmd,
    output gdad_pkg::sts_t        sts,
    input  logic [4:0]            start_day,
    input  logic [3:0]            start_month,
    input  logic [YEAR_BITS-1:0]  start_year,
    input  logic [ADD_BITS-1:0]   days_to_add,
    output logic [4:0]            end_day,
    output logic [3:0]            end_month,
    output logic [YEAR_BITS-1:0]  end_year,
    output logic                  year_overflow
);

    localparam int DAY_W = ADD_BITS + 1;

    logic [DAY_W-1:0]     day_reg, day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [4:0]           quot_reg, quot_next;
    logic [4:0]           rem_reg, rem_next;
    logic                 ovf_reg, ovf_next;

    logic [4:0]           out_day_reg;
    logic [3:0]           out_month_reg;
    logic [YEAR_BITS-1:0] out_year_reg;
    logic                 out_ovf_reg;

    logic                 leap;
    logic [4:0]           len;
    logic                 need_sub;
    logic [4:0]           month_inc;
    logic                 wrap;
    logic                 year_max;
    logic [39:0]          prod;

    // year mod 25 tracked in rem_reg, mod 4 and mod 16 come from the low year bits
    assign leap = (year_reg[1:0] == 2'b00) &&
                  ((rem_reg != 5'd0) || (year_reg[3:0] == 4'd0));
    assign len       = gdad_pkg::month_len(month_reg, leap);
    assign need_sub  = day_reg > DAY_W'(len);
    assign month_inc = {1'b0, month_reg} + 5'd1;
    assign wrap      = month_inc > {1'b0, gdad_pkg::MONTH_DEC};
    assign year_max  = &year_reg;
    assign prod      = 40'(start_year) * 40'(gdad_pkg::RECIP_25);

    assign sts.need_sub = need_sub;
    assign sts.wrap_ovf = need_sub && wrap && year_max;

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            day_next   = DAY_W'(start_day) + DAY_W'(days_to_add);
            month_next = start_month;
            year_next  = start_year;
            // low bits of year / 25 by reciprocal multiplication
            quot_next  = prod[gdad_pkg::RECIP_SHIFT +: 5];
            rem_next   = 5'd0;
            ovf_next   = 1'b0;
        end
        else if (cmd.mod_step)
        begin
            // the remainder fits in five bits, so year - 25 * quotient is taken mod 32
            rem_next = year_reg[4:0] - 5'(quot_reg * gdad_pkg::CENT_FACTOR);
        end
        else if (cmd.run_step && need_sub)
        begin
            day_next   = day_reg - DAY_W'(len);
            month_next = month_inc[3:0];
            if (wrap)
            begin
                if (year_max)
                begin
                    ovf_next   = 1'b1;
                    day_next   = DAY_W'(gdad_pkg::LEN_LONG);
                    month_next = gdad_pkg::MONTH_DEC;
                end
                else
                begin
                    month_next = gdad_pkg::MONTH_JAN;
                    year_next  = year_reg + 1'b1;
                    rem_next   = (rem_reg == 5'(gdad_pkg::CENT_FACTOR - 5'd1)) ? 5'd0
                                                                               : rem_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        ovf_reg   <= ovf_next;
        if (cmd.capture)
        begin
            out_day_reg   <= day_reg[4:0];
            out_month_reg <= month_reg;
            out_year_reg  <= year_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign end_day       = out_day_reg;
    assign end_month     = out_month_reg;
    assign end_year      = out_year_reg;
    assign year_overflow = out_ovf_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step |-> rem_reg < gdad_pkg::CENT_FACTOR)
        else $error("year remainder out of range");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step && sts.wrap_ovf |=>
            ovf_reg && day_reg == DAY_W'(gdad_pkg::LEN_LONG) && month_reg == gdad_pkg::MONTH_DEC)
        else $error("overflow did not saturate");

    a_wrap_jan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_step && need_sub && wrap && !year_max |=>
            month_reg == gdad_pkg::MONTH_JAN && year_reg == $past(year_reg) + 1'b1)
        else $error("december wrap wrong");

endmodule

@@ sv/gdad_ctrl.sv @@
module gdad_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  gdad_pkg::sts_t sts,
    output gdad_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                if (sts.need_sub)
                begin
                    cmd.run_step = 1'b1;
                    if (sts.wrap_ovf)
                        state_next = S_FIN;
                end
                else if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid_reg)
        else $error("captured result not presented");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped before taken");

endmodule

@@ sv/gregorian_date_add_days_unit.sv @@
// a transaction runs the load, year mod 25, month subtract and capture steps in that order,
// with one subtract step per month (about days_to_add/30, at most 135 for 12-bit counts);
// the subtract loop steps one month per cycle, and a new transaction is taken only after
// the last one is captured; a held result delays the capture and the input
// a finished result waits in an output register while the next transaction is taken
// reset (rst_n, async active low) clears the controller and output valid only
module gregorian_date_add_days_unit #(
    parameter int YEAR_BITS = gdad_pkg::YEAR_BITS_DEF,
    parameter int ADD_BITS  = gdad_pkg::ADD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [4:0]           start_day,
    input  logic [3:0]           start_month,
    input  logic [YEAR_BITS-1:0] start_year,
    input  logic [ADD_BITS-1:0]  days_to_add,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           end_day,
    output logic [3:0]           end_month,
    output logic [YEAR_BITS-1:0] end_year,
    output logic                 year_overflow
);

    gdad_pkg::cmd_t cmd;
    gdad_pkg::sts_t sts;

    gdad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gdad_dp #(
        .YEAR_BITS(YEAR_BITS),
        .ADD_BITS (ADD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .start_day     (start_day),
        .start_month   (start_month),
        .start_year    (start_year),
        .days_to_add   (days_to_add),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .year_overflow (year_overflow)
    );

endmodule
